### src/sfr_pkg.sv
// sfr_pkg: shared types, sizes and register codes for the stream find/replace block
// no dependencies
package sfr_pkg;

  localparam int MAX_BYTES = 8;              // longest pattern or replacement
  localparam int WIN_DEPTH = MAX_BYTES - 1;  // pending window cells
  localparam int CFG_W     = 64;

  typedef logic [7:0] byte_t;
  typedef logic [2:0] wcnt_t;   // window fill, 0..WIN_DEPTH
  typedef logic [3:0] len_t;    // lengths and burst sizes, 0..MAX_BYTES

  typedef enum logic [1:0] {
    REG_PATTERN_BYTES  = 2'd0,
    REG_PATTERN_LENGTH = 2'd1,
    REG_REPL_BYTES     = 2'd2,
    REG_REPL_LENGTH    = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic  take;
    wcnt_t count;
    len_t  drop;
  } win_ctl_t;

  typedef struct packed {
    logic load;
    logic shift;
  } emit_ctl_t;

  function automatic len_t clamp_len(len_t v);
    return (v > len_t'(MAX_BYTES)) ? len_t'(MAX_BYTES) : v;
  endfunction

endpackage

### src/sfr_if.sv
// sfr_in_if / sfr_out_if: valid/ready channels for raw and rewritten bytes
// depends on sfr_pkg
interface sfr_in_if;
  logic           valid;
  logic           ready;
  sfr_pkg::byte_t in_byte;
  logic           in_end;

  modport source (output valid, output in_byte, output in_end, input ready);
  modport sink   (input valid, input in_byte, input in_end, output ready);
endinterface

interface sfr_out_if;
  logic           valid;
  logic           ready;
  sfr_pkg::byte_t out_byte;
  logic           run_last;
  logic           stream_end;

  modport source (output valid, output out_byte, output run_last, output stream_end,
                  input ready);
  modport sink   (input valid, input out_byte, input run_last, input stream_end,
                  output ready);
endinterface

### src/sfr_win_cell.sv
// sfr_win_cell: one byte of the pending window, with its pattern compare
// depends on sfr_pkg
module sfr_win_cell (
  input  logic                                    clk,
  input  logic [2:0]                              index,
  input  sfr_pkg::win_ctl_t                       ctl,
  input  sfr_pkg::byte_t                          pat_byte,
  input  logic [sfr_pkg::MAX_BYTES-1:0][7:0]      step_buf,
  output sfr_pkg::byte_t                          held,
  output logic                                    ok
);
  import sfr_pkg::*;

  byte_t win_byte;
  len_t  src;

  // cells past the fill level do not take part in the compare
  assign ok   = (index >= ctl.count) || (win_byte == pat_byte);
  assign held = win_byte;
  assign src  = ctl.drop + len_t'(index);

  always_ff @(posedge clk) begin
    if (ctl.take) begin
      win_byte <= src[3] ? '0 : step_buf[src[2:0]];
    end
  end

endmodule

### src/sfr_emit_cell.sv
// sfr_emit_cell: one byte of the outgoing burst, shifts toward the head per beat
// depends on sfr_pkg
module sfr_emit_cell (
  input  logic                clk,
  input  sfr_pkg::emit_ctl_t  ctl,
  input  sfr_pkg::byte_t      load_byte,
  input  sfr_pkg::byte_t      next_byte,
  output sfr_pkg::byte_t      cur_byte
);
  import sfr_pkg::*;

  byte_t data;

  assign cur_byte = data;

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      data <= load_byte;
    end else if (ctl.shift) begin
      data <= next_byte;
    end
  end

endmodule

### src/stream_find_replace.sv
// stream_find_replace: streaming byte find and replace, top level
// depends on sfr_pkg, sfr_if, sfr_win_cell, sfr_emit_cell
//
//   channel  dir  payload                          beat when
//   din      in   in_byte, in_end                  din.valid & din.ready
//   dout     out  out_byte, run_last, stream_end   dout.valid & dout.ready
//   cfg      in   cfg_index, cfg_data              cfg_we
//
// a byte is taken on a din beat; its results leave from the emit chain one per cycle while dout.ready is high
// a beat is taken while the emit chain holds at most one byte that leaves this cycle,
// so a byte producing one result or none sustains one beat per cycle while dout.ready is high
// a burst of k results (replacement or flush) holds din until its last result is leaving
// reset clears lengths, patterns, window fill and emit count; no clearing pass
module stream_find_replace (
  input  logic                          clk,
  input  logic                          rst,
  sfr_in_if.sink                        din,
  sfr_out_if.source                     dout,
  input  logic                          cfg_we,
  input  logic [1:0]                    cfg_index,
  input  logic [sfr_pkg::CFG_W-1:0]     cfg_data
);
  import sfr_pkg::*;

  logic [63:0] pat_bytes;
  len_t        pat_len;
  logic [63:0] rep_bytes;
  len_t        rep_len;

  wcnt_t       win_cnt;
  len_t        emit_cnt;
  logic        emit_end;

  byte_t                       win_byte [WIN_DEPTH];
  logic [WIN_DEPTH-1:0]        win_ok;
  logic [MAX_BYTES-1:0][7:0]   step_buf;
  byte_t                       emit_byte [MAX_BYTES];

  len_t      plen, rlen, n, keep, drop, load_cnt;
  logic      enabled, hit, take, shift;
  byte_t     pat_at_cnt;
  win_ctl_t  win_ctl;
  emit_ctl_t emit_ctl;

  always_ff @(posedge clk) begin
    if (rst) begin
      pat_bytes <= '0;
      pat_len   <= '0;
      rep_bytes <= '0;
      rep_len   <= '0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_PATTERN_BYTES:  pat_bytes <= cfg_data[63:0];
        REG_PATTERN_LENGTH: pat_len   <= cfg_data[3:0];
        REG_REPL_BYTES:     rep_bytes <= cfg_data[63:0];
        REG_REPL_LENGTH:    rep_len   <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // window contents plus the incoming byte, oldest first
  always_comb begin
    for (int i = 0; i < WIN_DEPTH; i++) begin
      if (wcnt_t'(i) < win_cnt) begin
        step_buf[i] = win_byte[i];
      end else if (wcnt_t'(i) == win_cnt) begin
        step_buf[i] = din.in_byte;
      end else begin
        step_buf[i] = '0;
      end
    end
    step_buf[MAX_BYTES-1] = (win_cnt == wcnt_t'(WIN_DEPTH)) ? din.in_byte : '0;
  end

  assign plen       = clamp_len(pat_len);
  assign rlen       = clamp_len(rep_len);
  assign enabled    = (plen != '0) && (rlen != '0);
  assign n          = len_t'(win_cnt) + len_t'(1);
  assign pat_at_cnt = pat_bytes[{win_cnt, 3'b000} +: 8];
  assign hit        = enabled && (n == plen) && (&win_ok) && (din.in_byte == pat_at_cnt);

  always_comb begin
    if (!enabled || din.in_end) begin
      keep = '0;
    end else if (n > plen - len_t'(1)) begin
      keep = plen - len_t'(1);
    end else begin
      keep = n;
    end
  end

  assign drop     = n - keep;
  assign load_cnt = hit ? rlen : drop;

  assign take  = din.valid && din.ready;
  assign shift = dout.valid && dout.ready;

  assign din.ready       = (emit_cnt == '0) || ((emit_cnt == len_t'(1)) && dout.ready);
  assign dout.valid      = (emit_cnt != '0);
  assign dout.out_byte   = emit_byte[0];
  assign dout.run_last   = (emit_cnt == len_t'(1));
  assign dout.stream_end = (emit_cnt == len_t'(1)) && emit_end;

  assign win_ctl  = '{take: take, count: win_cnt, drop: drop};
  assign emit_ctl = '{load: take, shift: shift};

  always_ff @(posedge clk) begin
    if (rst) begin
      win_cnt  <= '0;
      emit_cnt <= '0;
      emit_end <= 1'b0;
    end else begin
      if (take) begin
        win_cnt  <= hit ? '0 : keep[2:0];
        emit_cnt <= load_cnt;
        emit_end <= din.in_end;
      end else if (shift) begin
        emit_cnt <= emit_cnt - len_t'(1);
      end
    end
  end

  for (genvar g = 0; g < WIN_DEPTH; g++) begin : g_win
    sfr_win_cell u_cell (
      .clk      (clk),
      .index    (3'(g)),
      .ctl      (win_ctl),
      .pat_byte (pat_bytes[g*8 +: 8]),
      .step_buf (step_buf),
      .held     (win_byte[g]),
      .ok       (win_ok[g])
    );
  end

  for (genvar g = 0; g < MAX_BYTES; g++) begin : g_emit
    byte_t next_b;
    if (g == MAX_BYTES - 1) begin : g_tail
      assign next_b = '0;
    end else begin : g_mid
      assign next_b = emit_byte[g+1];
    end
    sfr_emit_cell u_cell (
      .clk       (clk),
      .ctl       (emit_ctl),
      .load_byte (hit ? rep_bytes[g*8 +: 8] : step_buf[g]),
      .next_byte (next_b),
      .cur_byte  (emit_byte[g])
    );
  end

  // end of stream always empties the window
  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    (take && din.in_end) |=> (win_cnt == '0))
    else $error("window not empty after end of stream");

  // end of stream always yields at least one result
  a_end_emits: assert property (@(posedge clk) disable iff (rst)
    (take && din.in_end) |=> dout.valid)
    else $error("no result after end of stream");

  // stream end only on the closing byte of a burst
  a_end_last: assert property (@(posedge clk) disable iff (rst)
    (dout.valid && dout.stream_end) |-> dout.run_last)
    else $error("stream_end without run_last");

endmodule
